// ===== rtl/core/pctd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pctd_pkg;

	// fixed field widths
	localparam int OPCODE_W  = 2;
	localparam int CODE_W    = 16;
	localparam int CODELEN_W = 5;
	localparam int SYMBOL_W  = 8;
	localparam int STATUS_W  = 2;

	// longest code word; bounded by the code field width
	localparam int MAX_CODE_LEN = 16;

	// opcodes
	localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_DECODE = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_NONE   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SYMBOL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LOST   = 2'd3;

	typedef struct packed {
		logic [OPCODE_W-1:0]  opcode;
		logic [CODE_W-1:0]    code_bits;
		logic [CODELEN_W-1:0] code_length;
		logic [SYMBOL_W-1:0]  symbol_in;
		logic                 bit_value;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SYMBOL_W-1:0] symbol_out;
	} rsp_t;

	typedef struct packed {
		logic [CODE_W-1:0]    code;
		logic [CODELEN_W-1:0] length;
		logic [SYMBOL_W-1:0]  symbol;
	} entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/prefix_code_table_decoder_core.sv =====
// Prefix code table decoder.
// Command words arrive on cmd (cmd_valid / cmd_stall); one response word per
// command leaves on rsp (rsp_valid / rsp_stall). Opcodes: clear the table and
// the decode state, load a code word with its symbol, or feed one stream bit.
// Loads and decode bits search the table one entry per clock through a single
// read port of the table memory and one comparator, stopping at the first hit.
// No search is needed for a clear, an unused opcode, a load with a rejected
// length or a bit on a lost stream; cmd_stall is high from the acceptance of a
// command until its result is moved into the output register.
// The response sits in an output register; while rsp_stall is high the word
// holds and the next command may still be accepted and worked on, but its
// result waits until the register is free.
// Reset empties the table (entry count zero), the accumulated code and the
// lost flag; table memory contents are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module prefix_code_table_decoder_core #(
	parameter int TABLE_DEPTH  = 256
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cmd_valid,
	output logic             cmd_stall,
	input  pctd_pkg::cmd_t   cmd,
	output logic             rsp_valid,
	input  wire              rsp_stall,
	output pctd_pkg::rsp_t   rsp
);
	import pctd_pkg::*;

	localparam int AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW     = $clog2(TABLE_DEPTH + 1);
	localparam int LW     = $clog2(MAX_CODE_LEN + 1);
	localparam int PW     = MAX_CODE_LEN;
	localparam int KEY_W  = (PW > CODE_W) ? PW : CODE_W;
	localparam int KLEN_W = (LW > CODELEN_W) ? LW : CODELEN_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_DONE   = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       entry_cnt_q;
	logic [PW-1:0]       pend_code_q;
	logic [LW-1:0]       pend_len_q;
	logic                lost_q;
	logic [CW-1:0]       issue_idx_q;
	logic                chk_vld_s1;
	logic [AW-1:0]       chk_idx_s1;
	entry_t              rd_data_s1;
	logic                rsp_valid_q;
	rsp_t                rsp_q;

	logic [OPCODE_W-1:0] op_q;
	logic [KEY_W-1:0]    key_code_q;
	logic [KLEN_W-1:0]   key_len_q;
	logic [SYMBOL_W-1:0] sym_q;
	rsp_t                res_q;

	entry_t              table_mem [TABLE_DEPTH];

	logic                accept;
	logic                issue;
	logic                match;
	logic                hit;
	logic                miss;
	logic                full;
	logic                out_free;
	logic                out_load;
	logic                load_len_ok;
	logic                dec_lost;
	logic [CODE_W-1:0]   code_mask;
	logic [PW-1:0]       pend_code_nxt;
	logic [LW-1:0]       pend_len_nxt;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	entry_t              wr_data;

	always_comb begin
		for (int i = 0; i < CODE_W; i++) begin
			code_mask[i] = (CODELEN_W'(i) < cmd.code_length);
		end
	end

	assign accept        = cmd_valid && !cmd_stall;
	assign cmd_stall     = (state_q != S_IDLE);
	assign full          = (entry_cnt_q == CW'(TABLE_DEPTH));
	assign load_len_ok   = (cmd.code_length != '0) &&
	                       (int'(cmd.code_length) <= MAX_CODE_LEN);
	assign dec_lost      = lost_q || (pend_len_q >= LW'(MAX_CODE_LEN));
	// the accumulated code never reaches its top bit before the shift
	assign pend_code_nxt = {pend_code_q[PW-2:0], cmd.bit_value};
	assign pend_len_nxt  = pend_len_q + 1'b1;

	assign match = (KLEN_W'(rd_data_s1.length) == key_len_q) &&
	               (KEY_W'(rd_data_s1.code) == key_code_q);
	assign hit   = (state_q == S_SEARCH) && chk_vld_s1 && match;
	assign issue = (state_q == S_SEARCH) && !hit && (issue_idx_q < entry_cnt_q);
	assign miss  = (state_q == S_SEARCH) && !chk_vld_s1 && (issue_idx_q >= entry_cnt_q);

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign out_load = (state_q == S_DONE) && out_free;

	// a hit on a load rewrites the entry with its new symbol
	assign wr_en   = (op_q == OP_LOAD) && (hit || (miss && !full));
	assign wr_addr = hit ? chk_idx_s1 : entry_cnt_q[AW-1:0];
	always_comb begin
		wr_data.code   = CODE_W'(key_code_q);
		wr_data.length = CODELEN_W'(key_len_q);
		wr_data.symbol = sym_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			table_mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= table_mem[issue_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			entry_cnt_q <= '0;
			pend_code_q <= '0;
			pend_len_q  <= '0;
			lost_q      <= 1'b0;
			issue_idx_q <= '0;
			chk_vld_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			chk_vld_s1 <= issue;
			if (issue) begin
				issue_idx_q <= issue_idx_q + 1'b1;
			end

			case (state_q)
				S_IDLE: begin
					issue_idx_q <= '0;
					if (accept) begin
						state_q <= S_DONE;
						case (cmd.opcode)
							OP_CLEAR: begin
								entry_cnt_q <= '0;
								pend_code_q <= '0;
								pend_len_q  <= '0;
								lost_q      <= 1'b0;
							end
							OP_LOAD: begin
								if (load_len_ok) begin
									state_q <= S_SEARCH;
								end
							end
							OP_DECODE: begin
								if (dec_lost) begin
									lost_q <= 1'b1;
								end else begin
									pend_code_q <= pend_code_nxt;
									pend_len_q  <= pend_len_nxt;
									state_q     <= S_SEARCH;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						state_q <= S_DONE;
						if (op_q == OP_DECODE) begin
							pend_code_q <= '0;
							pend_len_q  <= '0;
						end
					end else if (miss) begin
						state_q <= S_DONE;
						if (op_q == OP_LOAD && !full) begin
							entry_cnt_q <= entry_cnt_q + 1'b1;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload side, no reset
	always_ff @(posedge clk) begin
		if (issue) begin
			chk_idx_s1 <= issue_idx_q[AW-1:0];
		end
		if (accept) begin
			op_q  <= cmd.opcode;
			sym_q <= cmd.symbol_in;
			res_q <= '{status: (cmd.opcode == OP_DECODE && dec_lost) ? ST_LOST : ST_NONE,
			           symbol_out: '0};
			if (cmd.opcode == OP_DECODE) begin
				key_code_q <= KEY_W'(pend_code_nxt);
				key_len_q  <= KLEN_W'(pend_len_nxt);
			end else begin
				key_code_q <= KEY_W'(cmd.code_bits & code_mask);
				key_len_q  <= KLEN_W'(cmd.code_length);
			end
		end else if (hit) begin
			if (op_q == OP_DECODE) begin
				res_q <= '{status: ST_SYMBOL, symbol_out: rd_data_s1.symbol};
			end
		end else if (miss) begin
			if (op_q == OP_LOAD && full) begin
				res_q.status <= ST_FULL;
			end
		end
		if (out_load) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_len_q <= LW'(MAX_CODE_LEN))
		else $error("accumulated code longer than limit");

	a_write_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SEARCH))
		else $error("table write outside search");

	a_check_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (state_q == S_SEARCH))
		else $error("compare stage live outside search");

	a_symbol_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status != ST_SYMBOL) |-> (rsp.symbol_out == '0))
		else $error("symbol set without symbol status");
`endif

endmodule

`default_nettype wire
